FILE: rtl/core/rpp_pkg.sv
// Package for the point rotation block: constants, data types, the arctangent
// table and the angle decoder. No dependencies.
`default_nettype none

package rpp_pkg;

   localparam int COORD_WIDTH_DEF     = 16;
   localparam int ROTATION_STAGES_DEF = 16;

   localparam int ANGLE_WIDTH  = 13;
   localparam int FULL_TURN    = 5760;
   localparam int QUARTER_TURN = 1440;
   localparam int EIGHTH_TURN  = 720;

   localparam int GAIN_WIDTH  = 25;
   localparam int GAIN_FRAC   = 24;
   localparam logic signed [GAIN_WIDTH-1:0] GAIN_Q24 = 25'sd10188014;

   localparam int GUARD_TOTAL   = 38;
   localparam int DATA_WIDTH    = 41;
   localparam int ANGLE_Z_WIDTH = 28;
   localparam int Z_SHIFT       = 16;
   localparam int ATAN_COUNT    = 24;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PIVOT_X = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PIVOT_Y = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGLE   = 2'd2;

   typedef struct packed {
      logic [1:0]                       quarter;
      logic signed [ANGLE_Z_WIDTH-1:0]  z;
   } angle_type;

   typedef struct packed {
      logic                             valid;
      logic signed [DATA_WIDTH-1:0]     x;
      logic signed [DATA_WIDTH-1:0]     y;
      logic signed [ANGLE_Z_WIDTH-1:0]  z;
   } beat_type;

   // Arctangent of 2^-i in units of 2^-20 degree.
   function automatic logic signed [ANGLE_Z_WIDTH-1:0] atan_entry(input int index);
      logic signed [ANGLE_Z_WIDTH-1:0] v;
      unique case (index)
         0:  v = 28'sd47185920;
         1:  v = 28'sd27855475;
         2:  v = 28'sd14718068;
         3:  v = 28'sd7471121;
         4:  v = 28'sd3750058;
         5:  v = 28'sd1876857;
         6:  v = 28'sd938658;
         7:  v = 28'sd469357;
         8:  v = 28'sd234682;
         9:  v = 28'sd117342;
         10: v = 28'sd58671;
         11: v = 28'sd29335;
         12: v = 28'sd14668;
         13: v = 28'sd7334;
         14: v = 28'sd3667;
         15: v = 28'sd1833;
         16: v = 28'sd917;
         17: v = 28'sd458;
         18: v = 28'sd229;
         19: v = 28'sd115;
         20: v = 28'sd57;
         21: v = 28'sd29;
         22: v = 28'sd14;
         23: v = 28'sd7;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Splits an angle code into quarter turns and a residual within one eighth turn.
   function automatic angle_type decode_angle(input logic [ANGLE_WIDTH-1:0] code);
      logic [ANGLE_WIDTH-1:0]      a;
      logic [1:0]                  q;
      logic signed [ANGLE_WIDTH:0] r;
      angle_type                   res;
      a = (code >= ANGLE_WIDTH'(FULL_TURN)) ? code - ANGLE_WIDTH'(FULL_TURN) : code;
      priority if (a >= ANGLE_WIDTH'(3 * QUARTER_TURN)) begin
         q = 2'd3;
      end else if (a >= ANGLE_WIDTH'(2 * QUARTER_TURN)) begin
         q = 2'd2;
      end else if (a >= ANGLE_WIDTH'(QUARTER_TURN)) begin
         q = 2'd1;
      end else begin
         q = 2'd0;
      end
      r = $signed({1'b0, a}) - $signed((ANGLE_WIDTH+1)'(int'(q) * QUARTER_TURN));
      if (r > $signed((ANGLE_WIDTH+1)'(EIGHTH_TURN))) begin
         r = r - $signed((ANGLE_WIDTH+1)'(QUARTER_TURN));
         q = q + 2'd1;
      end
      res.quarter = q;
      res.z       = ANGLE_Z_WIDTH'(r) <<< Z_SHIFT;
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rpp_scale.sv
// Front of the rotation pipeline: pivot subtraction, gain multiply and quarter turns.
// Depends on rpp_pkg.
`default_nettype none

module rpp_scale
   import rpp_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire logic signed [COORD_WIDTH-1:0] point_x,
   input  wire logic signed [COORD_WIDTH-1:0] point_y,
   input  wire logic signed [COORD_WIDTH-1:0] pivot_x,
   input  wire logic signed [COORD_WIDTH-1:0] pivot_y,
   input  wire angle_type                     angle,
   output beat_type                           dst_beat
);

   localparam int DIFF_WIDTH = COORD_WIDTH + 1;
   localparam int PROD_WIDTH = DIFF_WIDTH + GAIN_WIDTH;
   localparam int GUARD      = GUARD_TOTAL - COORD_WIDTH;
   localparam int LEFT       = (GUARD >= GAIN_FRAC) ? GUARD - GAIN_FRAC : 0;
   localparam int RIGHT      = (GUARD >= GAIN_FRAC) ? 0 : GAIN_FRAC - GUARD;
   localparam int WIDE_WIDTH = PROD_WIDTH + LEFT + 1;

   logic                          diff_valid_ff;
   logic signed [DIFF_WIDTH-1:0]  diff_x_ff;
   logic signed [DIFF_WIDTH-1:0]  diff_y_ff;
   logic signed [DIFF_WIDTH-1:0]  diff_x_in;
   logic signed [DIFF_WIDTH-1:0]  diff_y_in;
   logic signed [PROD_WIDTH-1:0]  prod_x;
   logic signed [PROD_WIDTH-1:0]  prod_y;
   logic signed [WIDE_WIDTH-1:0]  wide_x;
   logic signed [WIDE_WIDTH-1:0]  wide_y;
   logic signed [DATA_WIDTH-1:0]  scaled_x;
   logic signed [DATA_WIDTH-1:0]  scaled_y;
   beat_type                      dst_beat_in;
   beat_type                      dst_beat_ff;

   assign diff_x_in = DIFF_WIDTH'(point_x) - DIFF_WIDTH'(pivot_x);
   assign diff_y_in = DIFF_WIDTH'(point_y) - DIFF_WIDTH'(pivot_y);

   always_ff @(posedge clock) begin
      diff_x_ff     <= diff_x_in;
      diff_y_ff     <= diff_y_in;
      diff_valid_ff <= reset ? 1'b0 : load;
   end

   assign prod_x = PROD_WIDTH'(diff_x_ff) * PROD_WIDTH'(GAIN_Q24);
   assign prod_y = PROD_WIDTH'(diff_y_ff) * PROD_WIDTH'(GAIN_Q24);

   // The product carries GAIN_FRAC fraction bits; the datapath keeps GUARD of them.
   assign wide_x   = (WIDE_WIDTH'(prod_x) <<< LEFT) >>> RIGHT;
   assign wide_y   = (WIDE_WIDTH'(prod_y) <<< LEFT) >>> RIGHT;
   assign scaled_x = DATA_WIDTH'(wide_x);
   assign scaled_y = DATA_WIDTH'(wide_y);

   always_comb begin
      dst_beat_in.valid = diff_valid_ff && !reset;
      dst_beat_in.z     = angle.z;
      unique case (angle.quarter)
         2'd0: begin
            dst_beat_in.x = scaled_x;
            dst_beat_in.y = scaled_y;
         end
         2'd1: begin
            dst_beat_in.x = -scaled_y;
            dst_beat_in.y = scaled_x;
         end
         2'd2: begin
            dst_beat_in.x = -scaled_x;
            dst_beat_in.y = -scaled_y;
         end
         default: begin
            dst_beat_in.x = scaled_y;
            dst_beat_in.y = -scaled_x;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      dst_beat_ff <= dst_beat_in;
   end

   assign dst_beat = dst_beat_ff;

endmodule

`default_nettype wire

FILE: rtl/core/rpp_cordic_cell.sv
// One CORDIC micro-rotation cell of the rotation chain.
// Depends on rpp_pkg.
`default_nettype none

module rpp_cordic_cell
   import rpp_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire beat_type  src_beat,
   output beat_type       dst_beat
);

   localparam logic signed [ANGLE_Z_WIDTH-1:0] ATAN = atan_entry(STAGE);

   logic signed [DATA_WIDTH-1:0]    x_cur;
   logic signed [DATA_WIDTH-1:0]    y_cur;
   logic signed [ANGLE_Z_WIDTH-1:0] z_cur;
   logic signed [DATA_WIDTH-1:0]    dx;
   logic signed [DATA_WIDTH-1:0]    dy;
   beat_type                        dst_beat_in;
   beat_type                        dst_beat_ff;

   assign x_cur = src_beat.x;
   assign y_cur = src_beat.y;
   assign z_cur = src_beat.z;
   assign dx    = y_cur >>> STAGE;
   assign dy    = x_cur >>> STAGE;

   always_comb begin
      dst_beat_in.valid = src_beat.valid && !reset;
      if (!z_cur[ANGLE_Z_WIDTH-1]) begin
         dst_beat_in.x = x_cur - dx;
         dst_beat_in.y = y_cur + dy;
         dst_beat_in.z = z_cur - ATAN;
      end else begin
         dst_beat_in.x = x_cur + dx;
         dst_beat_in.y = y_cur - dy;
         dst_beat_in.z = z_cur + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      dst_beat_ff <= dst_beat_in;
   end

   assign dst_beat = dst_beat_ff;

endmodule

`default_nettype wire

FILE: rtl/core/rpp_output.sv
// Back of the rotation pipeline: rounding, pivot addition, saturation and result register.
// Depends on rpp_pkg.
`default_nettype none

module rpp_output
   import rpp_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire beat_type                      src_beat,
   input  wire logic signed [COORD_WIDTH-1:0] pivot_x,
   input  wire logic signed [COORD_WIDTH-1:0] pivot_y,
   output logic                               rsp_valid,
   output logic signed [COORD_WIDTH-1:0]      rsp_rotated_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_rotated_y
);

   localparam int GUARD = GUARD_TOTAL - COORD_WIDTH;
   localparam int RW    = DATA_WIDTH + 2;
   localparam logic signed [RW-1:0] HALF  = RW'(1) << (GUARD - 1);
   localparam logic signed [RW-1:0] MAX_V = {{(RW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [RW-1:0] MIN_V = ~MAX_V;

   logic                          valid_ff;
   logic signed [COORD_WIDTH-1:0] x_ff;
   logic signed [COORD_WIDTH-1:0] y_ff;
   logic signed [COORD_WIDTH-1:0] x_in;
   logic signed [COORD_WIDTH-1:0] y_in;

   function automatic logic signed [COORD_WIDTH-1:0] finish(
      input logic signed [DATA_WIDTH-1:0]  v,
      input logic signed [COORD_WIDTH-1:0] pivot
   );
      logic signed [RW-1:0]          total;
      logic signed [COORD_WIDTH-1:0] res;
      total = ((RW'(v) + HALF) >>> GUARD) + RW'(pivot);
      priority if (total > MAX_V) begin
         res = MAX_V[COORD_WIDTH-1:0];
      end else if (total < MIN_V) begin
         res = MIN_V[COORD_WIDTH-1:0];
      end else begin
         res = total[COORD_WIDTH-1:0];
      end
      return res;
   endfunction

   assign x_in = finish(src_beat.x, pivot_x);
   assign y_in = finish(src_beat.y, pivot_y);

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      valid_ff <= reset ? 1'b0 : src_beat.valid;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_rotated_x = x_ff;
   assign rsp_rotated_y = y_ff;

endmodule

`default_nettype wire

FILE: rtl/core/rotate_point_about_pivot_top.sv
// Top level of the point rotation block: configuration registers and the cell chain.
// Depends on rpp_pkg, rpp_scale, rpp_cordic_cell and rpp_output.
//
//   Channel   Ports                                  Word moves when
//   request   req_point_x, req_point_y               start high and busy low
//   response  rsp_rotated_x, rsp_rotated_y           rsp_valid high, one cycle
//   config    csr_index, csr_wdata                   csr_we high
//
// One word is accepted every cycle; busy is high only while reset is held.
// Each result passes through one register for the pivot subtraction, one for
// the gain multiply, one per CORDIC cell and one for rounding.
// Reset clears the pivot and the angle and drops all words in flight.
// The receiver cannot stall, so the chain advances in every cycle.
`default_nettype none

module rotate_point_about_pivot_top
   import rpp_pkg::*;
#(
   parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
   parameter int ROTATION_STAGES = ROTATION_STAGES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [COORD_WIDTH-1:0] req_point_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_point_y,
   output logic                               rsp_valid,
   output logic signed [COORD_WIDTH-1:0]      rsp_rotated_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_rotated_y,
   input  wire logic                          csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [((COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH)-1:0] csr_wdata
);

   logic signed [COORD_WIDTH-1:0] pivot_x_ff;
   logic signed [COORD_WIDTH-1:0] pivot_y_ff;
   logic signed [COORD_WIDTH-1:0] pivot_x_in;
   logic signed [COORD_WIDTH-1:0] pivot_y_in;
   angle_type                     angle_ff;
   angle_type                     angle_in;
   beat_type                      chain [ROTATION_STAGES+1];

   assign busy = reset;

   always_comb begin
      pivot_x_in = pivot_x_ff;
      pivot_y_in = pivot_y_ff;
      angle_in   = angle_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PIVOT_X: pivot_x_in = csr_wdata[COORD_WIDTH-1:0];
            CSR_PIVOT_Y: pivot_y_in = csr_wdata[COORD_WIDTH-1:0];
            CSR_ANGLE:   angle_in   = decode_angle(csr_wdata[ANGLE_WIDTH-1:0]);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pivot_x_ff <= '0;
         pivot_y_ff <= '0;
         angle_ff   <= '0;
      end else begin
         pivot_x_ff <= pivot_x_in;
         pivot_y_ff <= pivot_y_in;
         angle_ff   <= angle_in;
      end
   end

   rpp_scale #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_scale (
      .clock    (clock),
      .reset    (reset),
      .load     (start && !busy),
      .point_x  (req_point_x),
      .point_y  (req_point_y),
      .pivot_x  (pivot_x_ff),
      .pivot_y  (pivot_y_ff),
      .angle    (angle_ff),
      .dst_beat (chain[0])
   );

   for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_cell
      rpp_cordic_cell #(
         .STAGE (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .src_beat (chain[i]),
         .dst_beat (chain[i+1])
      );
   end

   rpp_output #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_output (
      .clock         (clock),
      .reset         (reset),
      .src_beat      (chain[ROTATION_STAGES]),
      .pivot_x       (pivot_x_ff),
      .pivot_y       (pivot_y_ff),
      .rsp_valid     (rsp_valid),
      .rsp_rotated_x (rsp_rotated_x),
      .rsp_rotated_y (rsp_rotated_y)
   );

endmodule

`default_nettype wire

FILE: rtl/core/rpp_checker.sv
// Port-level checks on the point rotation block, bound to its top level.
// Depends on rpp_pkg for the default stage count.
`default_nettype none

module rpp_checker
   import rpp_pkg::*;
#(
   parameter int ROTATION_STAGES = ROTATION_STAGES_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid
);

   localparam int LATENCY = ROTATION_STAGES + 3;

   a_busy_only_in_reset : assert property (@(posedge clock) busy |-> reset)
      else $error("busy raised outside reset");

   a_reset_clears_rsp : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response word present right after reset");

   a_word_answered : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted word produced no response at the expected cycle");

   a_no_spurious_rsp : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("response word without a matching request");

endmodule

bind rotate_point_about_pivot_top rpp_checker #(
   .ROTATION_STAGES (ROTATION_STAGES)
) u_rpp_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

`default_nettype wire

FILE: tb/rotate_point_about_pivot_checker.sv
// Checker for the point rotation block: watches the register port and both channels,
// predicts each rotated point and compares it with the block's response word.
// Depends on rpp_pkg for the coordinate width, stage count and register indexes.
module rotate_point_about_pivot_checker
   import rpp_pkg::*;
#(
   parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
   parameter int ROTATION_STAGES = ROTATION_STAGES_DEF,
   parameter int CSR_DATA_WIDTH  = (COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          busy,
   input  wire logic signed [COORD_WIDTH-1:0] req_point_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_point_y,
   input  wire logic                          rsp_valid,
   input  wire logic signed [COORD_WIDTH-1:0] rsp_rotated_x,
   input  wire logic signed [COORD_WIDTH-1:0] rsp_rotated_y,
   input  wire logic                          csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]     csr_wdata,
   output int                                 mismatch_count,
   output int                                 outstanding
);

   localparam int     GUARD_BITS   = 38 - COORD_WIDTH;
   localparam longint GAIN_Q24_VAL = 64'sd10188014;
   localparam int     GAIN_SHIFT   = 24;
   localparam longint ROUND_HALF   = longint'(1) <<< (GUARD_BITS - 1);
   localparam int     TURN_FULL    = 5760;
   localparam int     TURN_QUARTER = 1440;
   localparam int     TURN_EIGHTH  = 720;
   localparam int     REPORT_LIMIT = 60;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
   } rotated_point_type;

   logic signed [COORD_WIDTH-1:0] pivot_x;
   logic signed [COORD_WIDTH-1:0] pivot_y;
   logic [ANGLE_WIDTH-1:0]        angle_code;
   rotated_point_type             expected_rotations[$];
   rotated_point_type             got;
   rotated_point_type             want;

   function automatic longint atan_step_angle(input int stage);
      case (stage)
         0:  return 47185920;
         1:  return 27855475;
         2:  return 14718068;
         3:  return 7471121;
         4:  return 3750058;
         5:  return 1876857;
         6:  return 938658;
         7:  return 469357;
         8:  return 234682;
         9:  return 117342;
         10: return 58671;
         11: return 29335;
         12: return 14668;
         13: return 7334;
         14: return 3667;
         15: return 1833;
         16: return 917;
         17: return 458;
         18: return 229;
         19: return 115;
         20: return 57;
         21: return 29;
         22: return 14;
         23: return 7;
         default: return 0;
      endcase
   endfunction

   function automatic longint clamp_coord(input longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   function automatic rotated_point_type rotate_about_pivot(
      input logic signed [COORD_WIDTH-1:0] pt_x,
      input logic signed [COORD_WIDTH-1:0] pt_y
   );
      longint            x;
      longint            y;
      longint            t;
      longint            z;
      longint            r;
      longint            dx;
      longint            dy;
      int unsigned       a;
      int unsigned       q;
      int                i;
      rotated_point_type res;
      x = ((longint'(pt_x) - longint'(pivot_x)) * (longint'(1) <<< GUARD_BITS)
           * GAIN_Q24_VAL) >>> GAIN_SHIFT;
      y = ((longint'(pt_y) - longint'(pivot_y)) * (longint'(1) <<< GUARD_BITS)
           * GAIN_Q24_VAL) >>> GAIN_SHIFT;
      a = int'(angle_code) % TURN_FULL;
      q = a / TURN_QUARTER;
      r = longint'(a % TURN_QUARTER);
      if (r > TURN_EIGHTH) begin
         r = r - TURN_QUARTER;
         q = q + 1;
      end
      q = q & 3;
      for (i = 0; i < int'(q); i++) begin
         t = x;
         x = -y;
         y = t;
      end
      z = r * 65536;
      for (i = 0; i < ROTATION_STAGES && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - atan_step_angle(i);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + atan_step_angle(i);
         end
      end
      x = ((x + ROUND_HALF) >>> GUARD_BITS) + longint'(pivot_x);
      y = ((y + ROUND_HALF) >>> GUARD_BITS) + longint'(pivot_y);
      res.x = COORD_WIDTH'(clamp_coord(x));
      res.y = COORD_WIDTH'(clamp_coord(y));
      return res;
   endfunction

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
      pivot_x        = '0;
      pivot_y        = '0;
      angle_code     = '0;
   end

   always @(posedge clock) begin
      if (reset) begin
         pivot_x    = '0;
         pivot_y    = '0;
         angle_code = '0;
         expected_rotations.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PIVOT_X: pivot_x    = csr_wdata[COORD_WIDTH-1:0];
               CSR_PIVOT_Y: pivot_y    = csr_wdata[COORD_WIDTH-1:0];
               CSR_ANGLE:   angle_code = csr_wdata[ANGLE_WIDTH-1:0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            got.x = rsp_rotated_x;
            got.y = rsp_rotated_y;
            if (expected_rotations.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $error("response word (%0d, %0d) with no request waiting", got.x, got.y);
               end
            end else begin
               want = expected_rotations.pop_front();
               if (got.x !== want.x) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $error("rotated_x: expected %0d, actual %0d", want.x, got.x);
                  end
               end
               if (got.y !== want.y) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $error("rotated_y: expected %0d, actual %0d", want.y, got.y);
                  end
               end
            end
         end
         if (start && !busy) begin
            expected_rotations.push_back(rotate_about_pivot(req_point_x, req_point_y));
         end
      end
      outstanding <= expected_rotations.size();
   end

endmodule

FILE: tb/rotate_point_about_pivot_top_tb.sv
// Testbench top for the point rotation block: clock, reset, register writes and
// request words with random gaps. Depends on rpp_pkg, the block and the checker.
module rotate_point_about_pivot_top_tb;
   import rpp_pkg::*;

   localparam int CW             = COORD_WIDTH_DEF;
   localparam int CSR_DATA_WIDTH = (CW > ANGLE_WIDTH) ? CW : ANGLE_WIDTH;
   localparam int LATENCY        = ROTATION_STAGES_DEF + 3;
   localparam int RANDOM_POINTS  = 950;
   localparam int LIMIT_CYCLES   = 400000;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;

   logic                          clock     = 1'b0;
   logic                          reset     = 1'b1;
   logic                          start     = 1'b0;
   logic                          busy;
   logic signed [CW-1:0]          req_point_x = '0;
   logic signed [CW-1:0]          req_point_y = '0;
   logic                          rsp_valid;
   logic signed [CW-1:0]          rsp_rotated_x;
   logic signed [CW-1:0]          rsp_rotated_y;
   logic                          csr_we    = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]     csr_wdata = '0;
   int                            mismatch_count;
   int                            outstanding;
   int                            cycle_count = 0;
   int                            points_sent = 0;
   int                            settings_run = 0;
   logic signed [CW-1:0]          cur_pivot_x = '0;
   logic signed [CW-1:0]          cur_pivot_y = '0;

   rotate_point_about_pivot_top u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .rsp_valid     (rsp_valid),
      .rsp_rotated_x (rsp_rotated_x),
      .rsp_rotated_y (rsp_rotated_y),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   rotate_point_about_pivot_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .rsp_valid      (rsp_valid),
      .rsp_rotated_x  (rsp_rotated_x),
      .rsp_rotated_y  (rsp_rotated_y),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("rotate_point_about_pivot_top_tb: errors");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_PIVOT_X) begin
         cur_pivot_x = data[CW-1:0];
      end else if (idx == CSR_PIVOT_Y) begin
         cur_pivot_y = data[CW-1:0];
      end
      @(posedge clock);
   endtask

   task automatic end_writes();
      csr_we <= 1'b0;
      settings_run++;
   endtask

   task automatic set_regs(input logic signed [CW-1:0] px, input logic signed [CW-1:0] py,
                           input logic [CSR_DATA_WIDTH-1:0] angle_word);
      write_reg(CSR_PIVOT_X, px);
      write_reg(CSR_PIVOT_Y, py);
      write_reg(CSR_ANGLE, angle_word);
      end_writes();
   endtask

   task automatic send_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
      start       <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      do begin
         @(posedge clock);
      end while (busy);
      points_sent++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   task automatic idle_gap(input bit quiet);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      do begin
         @(posedge clock);
      end while (outstanding != 0);
   endtask

   task automatic send_set(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
      send_point(x, y);
      idle_gap(1'b0);
   endtask

   function automatic logic signed [CW-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return '0;
         3: return CW'($urandom_range(0, 511)) - CW'(256);
         default: return CW'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_WIDTH-1:0] pick_angle_word();
      logic [ANGLE_WIDTH-1:0] base;
      case ($urandom_range(0, 9))
         0: base = '0;
         1: base = ANGLE_WIDTH'(FULL_TURN - 1);
         2: base = ANGLE_WIDTH'(QUARTER_TURN * $urandom_range(0, 3));
         3: base = ANGLE_WIDTH'(QUARTER_TURN * $urandom_range(0, 3) + EIGHTH_TURN
                                + $urandom_range(0, 2) - 1);
         4: base = ANGLE_WIDTH'($urandom_range(FULL_TURN, (1 << ANGLE_WIDTH) - 1));
         default: base = ANGLE_WIDTH'($urandom_range(0, FULL_TURN - 1));
      endcase
      if ($urandom_range(0, 3) == 0) begin
         return {(CSR_DATA_WIDTH - ANGLE_WIDTH)'($urandom), base};
      end
      return CSR_DATA_WIDTH'(base);
   endfunction

   function automatic logic signed [CW-1:0] pick_point(input logic signed [CW-1:0] center);
      case ($urandom_range(0, 19))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2, 3: return center + CW'($urandom_range(0, 64)) - CW'(32);
         default: return CW'($urandom);
      endcase
   endfunction

   initial begin
      bit quiet;
      int count;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings rotate by zero about the origin.
      send_set(16'sh0000, 16'sh0000);
      send_set(16'sh7FFF, 16'sh7FFF);
      send_set(16'sh8000, 16'sh8000);
      drain();
      // Half turn about a corner pivot drives both coordinates of the far points into saturation.
      set_regs(16'sh8000, 16'sh7FFF, CSR_DATA_WIDTH'(2 * QUARTER_TURN));
      send_set(16'sh7FFF, 16'sh8000);
      send_set(16'sh8000, 16'sh7FFF);
      send_set(16'sh0000, 16'sh0000);
      drain();
      set_regs(16'sh7FFF, 16'sh8000, CSR_DATA_WIDTH'(FULL_TURN - 1));
      send_set(16'sh7FFF, 16'sh7FFF);
      send_set(16'sh8000, 16'sh8000);
      send_set(16'sh8000, 16'sh7FFF);
      drain();
      // Angle word with every bit set: upper bits dropped, code wraps past a full turn.
      set_regs(16'sh0000, 16'sh0000, '1);
      send_set(16'sd12345, -16'sd23456);
      send_set(16'sh7FFF, 16'sh0000);
      drain();
      // Exactly one full turn, then a write to the unused index that must change nothing.
      write_reg(CSR_ANGLE, CSR_DATA_WIDTH'(FULL_TURN));
      write_reg(CSR_UNUSED, 16'h1234);
      end_writes();
      send_set(16'sd1000, -16'sd1000);
      send_set(16'sh8000, 16'sh7FFF);
      drain();
      write_reg(CSR_ANGLE, CSR_DATA_WIDTH'(EIGHTH_TURN));
      end_writes();
      send_set(16'sd16000, 16'sd0);
      send_set(16'sd0, 16'sd16000);
      drain();
      write_reg(CSR_ANGLE, CSR_DATA_WIDTH'(EIGHTH_TURN + 1));
      end_writes();
      send_set(16'sd16000, 16'sd0);
      send_set(-16'sd16000, -16'sd1);
      drain();
      write_reg(CSR_ANGLE, CSR_DATA_WIDTH'(3 * QUARTER_TURN));
      end_writes();
      send_set(16'sh7FFF, 16'sh8000);
      send_set(16'sd1, -16'sd1);
      drain();

      count = points_sent + RANDOM_POINTS;
      while (points_sent < count) begin
         if ($urandom_range(0, 9) < 7) begin
            write_reg(CSR_PIVOT_X, pick_coord());
         end
         if ($urandom_range(0, 9) < 7) begin
            write_reg(CSR_PIVOT_Y, pick_coord());
         end
         if ($urandom_range(0, 9) < 8) begin
            write_reg(CSR_ANGLE, pick_angle_word());
         end
         if ($urandom_range(0, 9) == 0) begin
            write_reg(CSR_UNUSED, CSR_DATA_WIDTH'($urandom));
         end
         end_writes();
         quiet = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(10, 120)) begin
            send_point(pick_point(cur_pivot_x), pick_point(cur_pivot_y));
            idle_gap(quiet);
         end
         drain();
      end

      repeat (LATENCY + 4) @(posedge clock);
      $display("Rotated %0d points under %0d register settings, including wrapped angles,",
               points_sent, settings_run);
      $display("eighth-turn boundaries, corner pivots and saturated results.");
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("rotate_point_about_pivot_top_tb: clean");
      end else begin
         $display("rotate_point_about_pivot_top_tb: errors");
      end
      $finish;
   end

endmodule
